// File: hw/rtl/c8step_pkg.sv
// Shared types, codes and the hex font table for the CHIP-8 instruction step block.
`timescale 1ns / 1ps

package c8step_pkg;

    localparam int ADDR_W  = 12;
    localparam int BYTE_W  = 8;
    localparam int OP_W    = 16;
    localparam int STAT_W  = 3;
    localparam int DEPTH_W = 5;
    localparam int REG_N   = 16;
    localparam int RIDX_W  = 4;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 56;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [ADDR_W-1:0] PC_START  = 12'h200;
    localparam logic [ADDR_W-1:0] FONT_BASE = 12'h050;
    localparam logic [ADDR_W-1:0] FONT_LEN  = 12'd80;

    localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
    localparam logic [STAT_W-1:0] ST_SYS    = 3'd1;
    localparam logic [STAT_W-1:0] ST_UNDER  = 3'd2;
    localparam logic [STAT_W-1:0] ST_OVER   = 3'd3;
    localparam logic [STAT_W-1:0] ST_UNIMPL = 3'd4;

    localparam logic [OP_W-1:0] OP_CLS = 16'h00E0;
    localparam logic [OP_W-1:0] OP_RET = 16'h00EE;

    localparam logic [3:0] OPG_SYS     = 4'h0;
    localparam logic [3:0] OPG_JP      = 4'h1;
    localparam logic [3:0] OPG_CALL    = 4'h2;
    localparam logic [3:0] OPG_SE_IMM  = 4'h3;
    localparam logic [3:0] OPG_SNE_IMM = 4'h4;
    localparam logic [3:0] OPG_SE_REG  = 4'h5;
    localparam logic [3:0] OPG_LD_IMM  = 4'h6;
    localparam logic [3:0] OPG_ADD_IMM = 4'h7;
    localparam logic [3:0] OPG_ALU     = 4'h8;
    localparam logic [3:0] ALU_MOV     = 4'h0;

    localparam logic [BYTE_W-1:0] FONT [80] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    typedef struct packed {
        logic                is_step;
        logic [ADDR_W-1:0]   address;
        logic [BYTE_W-1:0]   data;
    } item_t;

    // First member is the most significant: status lands in the lowest bits.
    typedef struct packed {
        logic [DEPTH_W-1:0]  stack_depth;
        logic                screen_cleared;
        logic [BYTE_W-1:0]   reg_value;
        logic [RIDX_W-1:0]   reg_index;
        logic                reg_written;
        logic                skipped;
        logic [ADDR_W-1:0]   next_pc;
        logic [OP_W-1:0]     opcode_seen;
        logic [STAT_W-1:0]   status;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

// File: hw/rtl/c8step_front.sv
// Front end: accepts stream items, classifies them and buffers them in a two-entry queue.
`timescale 1ns / 1ps

module c8step_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                in_kind,
    input  logic [c8step_pkg::IN_DATA_W-1:0]    in_data,
    input  logic                                clearing,
    output c8step_pkg::item_t                   item,
    output logic                                item_valid,
    input  logic                                item_ready
);

    c8step_pkg::item_t                  q_mem [c8step_pkg::QUEUE_DEPTH];
    c8step_pkg::item_t                  in_item;
    logic [c8step_pkg::QPTR_W-1:0]      wp_reg;
    logic [c8step_pkg::QPTR_W-1:0]      wp_next;
    logic [c8step_pkg::QPTR_W-1:0]      rp_reg;
    logic [c8step_pkg::QPTR_W-1:0]      rp_next;
    logic [c8step_pkg::QCNT_W-1:0]      cnt_reg;
    logic [c8step_pkg::QCNT_W-1:0]      cnt_next;
    logic                               push;
    logic                               pop;

    always_comb
    begin
        in_item.is_step = in_kind;
        in_item.address = in_data[c8step_pkg::ADDR_W-1:0];
        in_item.data    = in_data[c8step_pkg::ADDR_W +: c8step_pkg::BYTE_W];
    end

    assign in_ready   = (cnt_reg != c8step_pkg::QCNT_W'(c8step_pkg::QUEUE_DEPTH)) && !clearing;
    assign item_valid = (cnt_reg != '0);
    assign item       = q_mem[rp_reg];
    assign push       = in_valid && in_ready;
    assign pop        = item_valid && item_ready;

    always_comb
    begin
        wp_next  = push ? wp_reg + 1'b1 : wp_reg;
        rp_next  = pop ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + c8step_pkg::QCNT_W'(push) - c8step_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wp_reg] <= in_item;
        end
    end

endmodule

// File: hw/rtl/c8step_back.sv
// Back end: program memory, register file, return stack and the fetch/decode/execute sequencer.
`timescale 1ns / 1ps

module c8step_back #(
    parameter int MEM_BYTES   = 4096,
    parameter int STACK_DEPTH = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  c8step_pkg::item_t       item,
    input  logic                    item_valid,
    output logic                    item_ready,
    output logic                    clearing,
    output c8step_pkg::result_t     res,
    output logic                    res_valid,
    input  logic                    res_ready
);

    localparam int AW = $clog2(MEM_BYTES);
    localparam int SW = $clog2(STACK_DEPTH + 1);
    localparam int IW = $clog2(STACK_DEPTH);
    localparam int AL = c8step_pkg::ADDR_W + 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_BYTES - 1);
    localparam logic [AL-1:0] MEM_LIMIT = AL'(MEM_BYTES);
    localparam logic [SW-1:0] SP_FULL   = SW'(STACK_DEPTH);

    localparam logic [1:0] PH_CLEAR  = 2'd0;
    localparam logic [1:0] PH_IDLE   = 2'd1;
    localparam logic [1:0] PH_DECODE = 2'd2;
    localparam logic [1:0] PH_EXEC   = 2'd3;

    logic [c8step_pkg::BYTE_W-1:0]  mem [MEM_BYTES];
    logic [c8step_pkg::BYTE_W-1:0]  gpr [c8step_pkg::REG_N];
    logic [c8step_pkg::ADDR_W-1:0]  stk [STACK_DEPTH];

    logic [1:0]                         phase_reg;
    logic [1:0]                         phase_next;
    logic [AW-1:0]                      clr_reg;
    logic [AW-1:0]                      clr_next;
    logic [c8step_pkg::ADDR_W-1:0]      pc_reg;
    logic [c8step_pkg::ADDR_W-1:0]      pc_next;
    logic [SW-1:0]                      sp_reg;
    logic [SW-1:0]                      sp_next;
    logic [c8step_pkg::REG_N-1:0]       rv_reg;
    logic [c8step_pkg::REG_N-1:0]       rv_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    c8step_pkg::result_t                out_reg;
    c8step_pkg::result_t                out_next;

    logic [c8step_pkg::BYTE_W-1:0]      rd0_reg;
    logic [c8step_pkg::BYTE_W-1:0]      rd1_reg;
    logic                               ok0_reg;
    logic                               ok1_reg;
    logic [c8step_pkg::OP_W-1:0]        op_reg;
    logic [c8step_pkg::BYTE_W-1:0]      vx_reg;
    logic [c8step_pkg::BYTE_W-1:0]      vy_reg;
    logic                               vx_ok_reg;
    logic                               vy_ok_reg;
    logic [c8step_pkg::ADDR_W-1:0]      stk_rd_reg;

    logic                               slot_free;
    logic                               fire;
    logic                               wr_fire;
    logic                               rd_en;
    logic                               commit;
    logic [c8step_pkg::ADDR_W-1:0]      fa0;
    logic [c8step_pkg::ADDR_W-1:0]      fa1;
    logic                               fa0_in;
    logic                               fa1_in;
    logic                               wa_in;
    logic                               mem_we;
    logic [AW-1:0]                      mem_wa;
    logic [c8step_pkg::BYTE_W-1:0]      mem_wd;
    logic [c8step_pkg::ADDR_W-1:0]      font_off;
    logic [c8step_pkg::OP_W-1:0]        opcode;
    logic [SW-1:0]                      sp_dec;

    logic [c8step_pkg::RIDX_W-1:0]      x;
    logic [c8step_pkg::BYTE_W-1:0]      nn;
    logic [c8step_pkg::BYTE_W-1:0]      vx;
    logic [c8step_pkg::BYTE_W-1:0]      vy;
    logic [c8step_pkg::ADDR_W-1:0]      pc2;
    logic [c8step_pkg::ADDR_W-1:0]      pc4;
    logic [c8step_pkg::STAT_W-1:0]      ex_status;
    logic [c8step_pkg::ADDR_W-1:0]      ex_pc;
    logic [SW-1:0]                      ex_sp;
    logic                               ex_skip;
    logic                               ex_wr;
    logic [c8step_pkg::BYTE_W-1:0]      ex_val;
    logic                               ex_cls;
    logic                               ex_push;

    assign clearing  = (phase_reg == PH_CLEAR);
    assign slot_free = !out_valid_reg || res_ready;
    assign item_ready = (phase_reg == PH_IDLE) && (item.is_step || slot_free);
    assign fire      = item_valid && item_ready;
    assign wr_fire   = fire && !item.is_step;
    assign rd_en     = fire && item.is_step;
    assign commit    = (phase_reg == PH_EXEC) && slot_free;
    assign res       = out_reg;
    assign res_valid = out_valid_reg;

    assign fa0    = pc_reg;
    assign fa1    = pc_reg + 12'd1;
    assign fa0_in = ({1'b0, fa0} < MEM_LIMIT);
    assign fa1_in = ({1'b0, fa1} < MEM_LIMIT);
    assign wa_in  = ({1'b0, item.address} < MEM_LIMIT);

    assign font_off = c8step_pkg::ADDR_W'(clr_reg) - c8step_pkg::FONT_BASE;

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = clr_reg;
        mem_wd = '0;
        if (phase_reg == PH_CLEAR)
        begin
            mem_we = 1'b1;
            if (font_off < c8step_pkg::FONT_LEN)
            begin
                mem_wd = c8step_pkg::FONT[font_off[6:0]];
            end
        end
        else if (wr_fire && wa_in)
        begin
            mem_we = 1'b1;
            mem_wa = item.address[AW-1:0];
            mem_wd = item.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en)
        begin
            ok0_reg <= fa0_in;
            ok1_reg <= fa1_in;
            if (fa0_in)
            begin
                rd0_reg <= mem[fa0[AW-1:0]];
            end
            if (fa1_in)
            begin
                rd1_reg <= mem[fa1[AW-1:0]];
            end
        end
    end

    assign opcode = {ok0_reg ? rd0_reg : 8'h00, ok1_reg ? rd1_reg : 8'h00};
    assign sp_dec = sp_reg - SW'(1);

    always_ff @(posedge clk)
    begin
        if (phase_reg == PH_DECODE)
        begin
            op_reg    <= opcode;
            vx_reg    <= gpr[opcode[11:8]];
            vy_reg    <= gpr[opcode[7:4]];
            vx_ok_reg <= rv_reg[opcode[11:8]];
            vy_ok_reg <= rv_reg[opcode[7:4]];
            if (sp_reg != '0)
            begin
                stk_rd_reg <= stk[sp_dec[IW-1:0]];
            end
        end
        if (commit && ex_wr)
        begin
            gpr[x] <= ex_val;
        end
        if (commit && ex_push)
        begin
            stk[sp_reg[IW-1:0]] <= pc2;
        end
    end

    assign x   = op_reg[11:8];
    assign nn  = op_reg[7:0];
    assign vx  = vx_ok_reg ? vx_reg : 8'h00;
    assign vy  = vy_ok_reg ? vy_reg : 8'h00;
    assign pc2 = pc_reg + 12'd2;
    assign pc4 = pc_reg + 12'd4;

    always_comb
    begin
        ex_status = c8step_pkg::ST_OK;
        ex_pc     = pc2;
        ex_sp     = sp_reg;
        ex_skip   = 1'b0;
        ex_wr     = 1'b0;
        ex_val    = '0;
        ex_cls    = 1'b0;
        ex_push   = 1'b0;
        unique case (op_reg[15:12])
            c8step_pkg::OPG_SYS:
            begin
                if (op_reg == c8step_pkg::OP_CLS)
                begin
                    ex_cls = 1'b1;
                end
                else if (op_reg == c8step_pkg::OP_RET)
                begin
                    if (sp_reg == '0)
                    begin
                        ex_status = c8step_pkg::ST_UNDER;
                    end
                    else
                    begin
                        ex_sp = sp_dec;
                        ex_pc = stk_rd_reg;
                    end
                end
                else
                begin
                    ex_status = c8step_pkg::ST_SYS;
                end
            end
            c8step_pkg::OPG_JP:
            begin
                ex_pc = op_reg[11:0];
            end
            c8step_pkg::OPG_CALL:
            begin
                if (sp_reg == SP_FULL)
                begin
                    ex_status = c8step_pkg::ST_OVER;
                    ex_pc     = pc_reg;
                end
                else
                begin
                    ex_push = 1'b1;
                    ex_sp   = sp_reg + SW'(1);
                    ex_pc   = op_reg[11:0];
                end
            end
            c8step_pkg::OPG_SE_IMM:
            begin
                ex_skip = (vx == nn);
                ex_pc   = ex_skip ? pc4 : pc2;
            end
            c8step_pkg::OPG_SNE_IMM:
            begin
                ex_skip = (vx != nn);
                ex_pc   = ex_skip ? pc4 : pc2;
            end
            c8step_pkg::OPG_SE_REG:
            begin
                ex_skip = (vx == vy);
                ex_pc   = ex_skip ? pc4 : pc2;
            end
            c8step_pkg::OPG_LD_IMM:
            begin
                ex_wr  = 1'b1;
                ex_val = nn;
            end
            c8step_pkg::OPG_ADD_IMM:
            begin
                ex_wr  = 1'b1;
                ex_val = vx + nn;
            end
            c8step_pkg::OPG_ALU:
            begin
                if (op_reg[3:0] == c8step_pkg::ALU_MOV)
                begin
                    ex_wr  = 1'b1;
                    ex_val = vy;
                end
                else
                begin
                    ex_status = c8step_pkg::ST_UNIMPL;
                    ex_pc     = pc_reg;
                end
            end
            default:
            begin
                ex_status = c8step_pkg::ST_UNIMPL;
                ex_pc     = pc_reg;
            end
        endcase
    end

    always_comb
    begin
        phase_next     = phase_reg;
        clr_next       = clr_reg;
        pc_next        = pc_reg;
        sp_next        = sp_reg;
        rv_next        = rv_reg;
        out_valid_next = out_valid_reg && !res_ready;
        unique case (phase_reg)
            PH_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == LAST_ADDR)
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_IDLE:
            begin
                if (rd_en)
                begin
                    phase_next = PH_DECODE;
                end
                if (wr_fire)
                begin
                    out_valid_next = 1'b1;
                end
            end
            PH_DECODE:
            begin
                phase_next = PH_EXEC;
            end
            PH_EXEC:
            begin
                if (commit)
                begin
                    phase_next     = PH_IDLE;
                    out_valid_next = 1'b1;
                    pc_next        = ex_pc;
                    sp_next        = ex_sp;
                    if (ex_wr)
                    begin
                        rv_next = rv_reg | (c8step_pkg::REG_N'(1) << x);
                    end
                end
            end
            default:
            begin
                phase_next = PH_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        out_next = out_reg;
        if (wr_fire)
        begin
            out_next                = '0;
            out_next.next_pc        = pc_reg;
            out_next.stack_depth    = c8step_pkg::DEPTH_W'(sp_reg);
        end
        else if (commit)
        begin
            out_next.status         = ex_status;
            out_next.opcode_seen    = op_reg;
            out_next.next_pc        = ex_pc;
            out_next.skipped        = ex_skip;
            out_next.reg_written    = ex_wr;
            out_next.reg_index      = ex_wr ? x : '0;
            out_next.reg_value      = ex_val;
            out_next.screen_cleared = ex_cls;
            out_next.stack_depth    = c8step_pkg::DEPTH_W'(ex_sp);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_CLEAR;
            clr_reg       <= '0;
            pc_reg        <= c8step_pkg::PC_START;
            sp_reg        <= '0;
            rv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            clr_reg       <= clr_next;
            pc_reg        <= pc_next;
            sp_reg        <= sp_next;
            rv_reg        <= rv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

// File: hw/rtl/chip8_instruction_step.sv
// Top level of the CHIP-8 instruction step block.
`timescale 1ns / 1ps

// CHIP-8 instruction step core: a write transfer (tuser 0) stores one byte into the program
// memory and a step transfer (tuser 1) executes the instruction at pc; every input transfer
// yields exactly one result transfer. After reset the core clears the whole memory and loads
// the hex font at 0x50, with s_axis_tready low. A step then reads both opcode bytes from the
// two read ports of the program memory, reads the register file and return stack, then
// executes the instruction. A two-entry queue sits between the input and the sequencer, and the
// result register lets the next step start while a result waits on m_axis_tready; a write waits
// until the result register is free.
module chip8_instruction_step #(
    parameter int MEM_BYTES   = 4096,
    parameter int STACK_DEPTH = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // address[11:0], data[19:12], zero[23:20]
    input  logic [c8step_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // action[0]
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // status[2:0], opcode_seen[18:3], next_pc[30:19], skipped[31], reg_written[32],
    // reg_index[36:33], reg_value[44:37], screen_cleared[45], stack_depth[50:46], zero[55:51]
    output logic [c8step_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    c8step_pkg::item_t      item;
    logic                   item_valid;
    logic                   item_ready;
    logic                   clearing;
    c8step_pkg::result_t    res;

    c8step_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_kind    (s_axis_tuser),
        .in_data    (s_axis_tdata),
        .clearing   (clearing),
        .item       (item),
        .item_valid (item_valid),
        .item_ready (item_ready)
    );

    c8step_back #(
        .MEM_BYTES   (MEM_BYTES),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .clearing   (clearing),
        .res        (res),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready)
    );

    assign m_axis_tdata = c8step_pkg::OUT_DATA_W'(res);

endmodule

// File: verif/tb.sv
// Self-checking testbench for chip8_instruction_step: stream driver, result monitor and step predictor.
`timescale 1ns / 1ps

module tb;

    localparam int MEM_N      = 4096;
    localparam int STACK_N    = 16;
    localparam int STALL_MAX  = 20000;
    localparam int PHASE_ITEMS = 400;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [c8step_pkg::IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic                               s_axis_tuser = 1'b0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic [c8step_pkg::OUT_DATA_W-1:0]  m_axis_tdata;

    chip8_instruction_step #(
        .MEM_BYTES   (MEM_N),
        .STACK_DEPTH (STACK_N)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    logic [c8step_pkg::BYTE_W-1:0]  mem_img [MEM_N];
    logic [c8step_pkg::BYTE_W-1:0]  vreg [c8step_pkg::REG_N];
    logic [c8step_pkg::ADDR_W-1:0]  ret_stack [STACK_N];
    logic [c8step_pkg::ADDR_W-1:0]  model_pc;
    logic [c8step_pkg::DEPTH_W-1:0] call_depth;

    c8step_pkg::item_t   items_to_send[$];
    c8step_pkg::result_t step_results_due[$];
    c8step_pkg::item_t   send_item;
    c8step_pkg::result_t got_result;
    c8step_pkg::result_t want_result;

    int send_gap_pct = 20;
    int recv_gap_pct = 70;
    int issued = 0;
    int errors = 0;
    int stall_cycles = 0;

    initial begin
        forever #6 clk = ~clk;
    end

    function automatic void reset_model();
        for (int i = 0; i < MEM_N; i++)
            mem_img[i] = '0;
        for (int i = 0; i < 80; i++)
            mem_img[c8step_pkg::FONT_BASE + i] = c8step_pkg::FONT[i];
        for (int i = 0; i < c8step_pkg::REG_N; i++)
            vreg[i] = '0;
        for (int i = 0; i < STACK_N; i++)
            ret_stack[i] = '0;
        model_pc = c8step_pkg::PC_START;
        call_depth = '0;
    endfunction

    function automatic c8step_pkg::result_t execute_item(input c8step_pkg::item_t it);
        c8step_pkg::result_t           r;
        logic [c8step_pkg::OP_W-1:0]   op;
        logic [c8step_pkg::ADDR_W-1:0] pc;
        logic [c8step_pkg::ADDR_W-1:0] pc_lo;
        logic [3:0]                    x;
        logic [3:0]                    y;
        logic [7:0]                    nn;
        r = '0;
        pc = model_pc;
        if (!it.is_step) begin
            mem_img[it.address] = it.data;
        end
        else begin
            pc_lo = pc + 12'd1;
            op = {mem_img[pc], mem_img[pc_lo]};
            x = op[11:8];
            y = op[7:4];
            nn = op[7:0];
            r.opcode_seen = op;
            case (op[15:12])
                c8step_pkg::OPG_SYS: begin
                    if (op == c8step_pkg::OP_CLS) begin
                        r.screen_cleared = 1'b1;
                        pc = pc + 12'd2;
                    end
                    else if (op == c8step_pkg::OP_RET) begin
                        if (call_depth == 0) begin
                            r.status = c8step_pkg::ST_UNDER;
                            pc = pc + 12'd2;
                        end
                        else begin
                            call_depth = call_depth - 1'b1;
                            pc = ret_stack[call_depth];
                        end
                    end
                    else begin
                        r.status = c8step_pkg::ST_SYS;
                        pc = pc + 12'd2;
                    end
                end
                c8step_pkg::OPG_JP: pc = op[11:0];
                c8step_pkg::OPG_CALL: begin
                    if (call_depth >= STACK_N) begin
                        r.status = c8step_pkg::ST_OVER;
                    end
                    else begin
                        ret_stack[call_depth] = pc + 12'd2;
                        call_depth = call_depth + 1'b1;
                        pc = op[11:0];
                    end
                end
                c8step_pkg::OPG_SE_IMM, c8step_pkg::OPG_SNE_IMM, c8step_pkg::OPG_SE_REG: begin
                    if (op[15:12] == c8step_pkg::OPG_SE_IMM)
                        r.skipped = (vreg[x] == nn);
                    else if (op[15:12] == c8step_pkg::OPG_SNE_IMM)
                        r.skipped = (vreg[x] != nn);
                    else
                        r.skipped = (vreg[x] == vreg[y]);
                    pc = pc + (r.skipped ? 12'd4 : 12'd2);
                end
                c8step_pkg::OPG_LD_IMM, c8step_pkg::OPG_ADD_IMM: begin
                    r.reg_value = (op[15:12] == c8step_pkg::OPG_LD_IMM) ? nn : vreg[x] + nn;
                    vreg[x] = r.reg_value;
                    r.reg_written = 1'b1;
                    r.reg_index = x;
                    pc = pc + 12'd2;
                end
                c8step_pkg::OPG_ALU: begin
                    if (op[3:0] == c8step_pkg::ALU_MOV) begin
                        r.reg_value = vreg[y];
                        vreg[x] = r.reg_value;
                        r.reg_written = 1'b1;
                        r.reg_index = x;
                        pc = pc + 12'd2;
                    end
                    else begin
                        r.status = c8step_pkg::ST_UNIMPL;
                    end
                end
                default: r.status = c8step_pkg::ST_UNIMPL;
            endcase
            model_pc = pc;
        end
        r.next_pc = model_pc;
        r.stack_depth = call_depth;
        return r;
    endfunction

    function automatic logic [c8step_pkg::OP_W-1:0] pick_op();
        logic [3:0]                    x;
        logic [3:0]                    y;
        logic [3:0]                    n;
        logic [3:0]                    grp;
        logic [7:0]                    nn;
        logic [c8step_pkg::ADDR_W-1:0] nnn;
        logic [c8step_pkg::OP_W-1:0]   op;
        x = 4'($urandom_range(0, 15));
        y = 4'($urandom_range(0, 15));
        n = 4'($urandom_range(0, 15));
        grp = 4'($urandom_range(9, 15));
        nn = 8'($urandom_range(0, 255));
        nnn = 12'($urandom_range(0, 4095));
        if ($urandom_range(0, 7) == 0)
            nnn = 12'hFFE + 12'($urandom_range(0, 1));
        case ($urandom_range(0, 19))
            0: op = c8step_pkg::OP_CLS;
            1: op = c8step_pkg::OP_RET;
            2: op = {c8step_pkg::OPG_SYS, nnn};
            3: op = {c8step_pkg::OPG_JP, nnn};
            4: op = {c8step_pkg::OPG_CALL, nnn};
            5: op = {c8step_pkg::OPG_SE_IMM, x, ($urandom_range(0, 1) ? vreg[x] : nn)};
            6: op = {c8step_pkg::OPG_SNE_IMM, x, ($urandom_range(0, 1) ? vreg[x] : nn)};
            7: op = {c8step_pkg::OPG_SE_REG, x, y, n};
            8, 14, 15: op = {c8step_pkg::OPG_LD_IMM, x, nn};
            9, 16, 17: op = {c8step_pkg::OPG_ADD_IMM, x, nn};
            10, 18: op = {c8step_pkg::OPG_ALU, x, y, c8step_pkg::ALU_MOV};
            11: op = {c8step_pkg::OPG_ALU, x, y, (n == c8step_pkg::ALU_MOV) ? 4'h1 : n};
            12: op = {grp, nnn};
            default: op = {c8step_pkg::OPG_SE_REG, x, x, n};
        endcase
        return op;
    endfunction

    task automatic push_item(input logic act, input logic [c8step_pkg::ADDR_W-1:0] addr,
                             input logic [c8step_pkg::BYTE_W-1:0] byt);
        c8step_pkg::item_t it;
        it.is_step = act;
        it.address = addr;
        it.data = byt;
        step_results_due.push_back(execute_item(it));
        items_to_send.push_back(it);
        issued++;
    endtask

    task automatic push_step();
        push_item(1'b1, 12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)));
    endtask

    task automatic load_and_run(input logic [c8step_pkg::OP_W-1:0] op);
        push_item(1'b0, model_pc, op[15:8]);
        push_item(1'b0, model_pc + 12'd1, op[7:0]);
        push_step();
    endtask

    task automatic run_random(input int count);
        int stop_at;
        int k;
        int reps;
        stop_at = issued + count;
        while (issued < stop_at) begin
            k = $urandom_range(0, 99);
            if (k < 8) begin
                push_item(1'b0, 12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)));
            end
            else if (k < 12) begin
                push_step();
            end
            else if (k < 14) begin
                reps = $urandom_range(STACK_N, STACK_N + 2);
                repeat (reps)
                    load_and_run({c8step_pkg::OPG_CALL, 12'($urandom_range(0, 4095))});
                reps = $urandom_range(STACK_N, STACK_N + 2);
                repeat (reps)
                    load_and_run(c8step_pkg::OP_RET);
            end
            else begin
                load_and_run(pick_op());
            end
        end
    endtask

    task automatic wait_drained();
        while (items_to_send.size() > 0 || step_results_due.size() > 0)
            @(negedge clk);
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= 1'b0;
        end
        else if (!s_axis_tvalid || s_axis_tready) begin
            if (items_to_send.size() > 0 && $urandom_range(0, 99) >= send_gap_pct) begin
                send_item = items_to_send.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {4'b0000, send_item.data, send_item.address};
                s_axis_tuser <= send_item.is_step;
            end
            else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
        end
        else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_result = m_axis_tdata[c8step_pkg::RESULT_W-1:0];
                if (step_results_due.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected transfer: tdata %h", m_axis_tdata);
                end
                else begin
                    want_result = step_results_due.pop_front();
                    if (got_result.status != want_result.status
                        || got_result.opcode_seen != want_result.opcode_seen
                        || got_result.next_pc != want_result.next_pc
                        || got_result.skipped != want_result.skipped
                        || got_result.reg_written != want_result.reg_written
                        || got_result.reg_index != want_result.reg_index
                        || got_result.reg_value != want_result.reg_value
                        || got_result.screen_cleared != want_result.screen_cleared
                        || got_result.stack_depth != want_result.stack_depth) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch (exp/act): status %0d/%0d op %h/%h pc %h/%h",
                                     want_result.status, got_result.status,
                                     want_result.opcode_seen, got_result.opcode_seen,
                                     want_result.next_pc, got_result.next_pc,
                                     " skip %0d/%0d wr %0d/%0d idx %0d/%0d val %h/%h",
                                     want_result.skipped, got_result.skipped,
                                     want_result.reg_written, got_result.reg_written,
                                     want_result.reg_index, got_result.reg_index,
                                     want_result.reg_value, got_result.reg_value,
                                     " cls %0d/%0d depth %0d/%0d",
                                     want_result.screen_cleared, got_result.screen_cleared,
                                     want_result.stack_depth, got_result.stack_depth);
                    end
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_gap_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                stall_cycles = 0;
            end
            else if (stall_cycles >= STALL_MAX) begin
                $display("RESULT: ERROR");
                $finish;
            end
            else begin
                stall_cycles++;
            end
        end
    end

    initial begin
        reset_model();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        push_item(1'b0, 12'h000, 8'hFF);
        push_item(1'b0, 12'hFFF, 8'h00);
        push_item(1'b1, 12'hFFF, 8'hFF);
        load_and_run(c8step_pkg::OP_CLS);
        load_and_run(c8step_pkg::OP_RET);
        load_and_run({c8step_pkg::OPG_LD_IMM, 4'hF, 8'hFF});
        load_and_run({c8step_pkg::OPG_ADD_IMM, 4'hF, 8'h01});
        load_and_run({c8step_pkg::OPG_SE_REG, 4'h0, 4'h1, 4'h1});
        load_and_run({c8step_pkg::OPG_ALU, 4'h1, 4'h2, 4'h1});
        load_and_run(16'hF000);
        run_random(PHASE_ITEMS);
        wait_drained();

        send_gap_pct = 70;
        recv_gap_pct = 20;
        run_random(PHASE_ITEMS);
        wait_drained();

        send_gap_pct = 0;
        recv_gap_pct = 0;
        run_random(PHASE_ITEMS);
        wait_drained();

        repeat (20) @(negedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
